@@ rtl/msbr_pkg.sv @@
// Shared types and constants for the MSB-first bit reader.
package msbr_pkg;

    // Default sizes handed to the top level parameters
    localparam int unsigned STORE_BYTES_DEF   = 4096;
    localparam int unsigned MAX_READ_BITS_DEF = 32;

    // Field widths
    localparam int unsigned OPCODE_W    = 3;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned BIT_COUNT_W = 6;
    localparam int unsigned SKIP_W      = 13;
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned ALIGN_W     = 3;

    // Stream word widths
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 40;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 3'd0,
        OP_READ   = 3'd1,
        OP_SKIP   = 3'd2,
        OP_REWIND = 3'd3,
        OP_CLEAR  = 3'd4
    } msbr_op_t;

    typedef struct packed {
        logic [ALIGN_W-1:0] bits_to_alignment;
        logic               out_of_bounds;
        logic [VALUE_W-1:0] bits_value;
    } msbr_result_t;

endpackage

@@ rtl/msbr_store.sv @@
// Single-port byte store with registered read data.
module msbr_store #(
    parameter int unsigned DEPTH = msbr_pkg::STORE_BYTES_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic                        we,
    input  logic [AW-1:0]               addr,
    input  logic [msbr_pkg::BYTE_W-1:0] wdata,
    output logic [msbr_pkg::BYTE_W-1:0] rdata
);

    logic [msbr_pkg::BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

@@ rtl/msbr_core.sv @@
// Sequencer and shift accumulator: executes one command, fetching read bytes one a cycle.
module msbr_core #(
    parameter int unsigned STORE_BYTES   = msbr_pkg::STORE_BYTES_DEF,
    parameter int unsigned MAX_READ_BITS = msbr_pkg::MAX_READ_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [msbr_pkg::OPCODE_W-1:0]    opcode,
    input  logic [msbr_pkg::BYTE_W-1:0]      byte_value,
    input  logic [msbr_pkg::BIT_COUNT_W-1:0] bit_count,
    input  logic [msbr_pkg::SKIP_W-1:0]      skip_count,
    output logic                             ready,
    output logic                             res_valid,
    input  logic                             res_take,
    output msbr_pkg::msbr_result_t           result
);

    localparam int unsigned AW        = $clog2(STORE_BYTES);
    localparam int unsigned PW        = $clog2(STORE_BYTES + 1);
    localparam int unsigned CW        = (PW > msbr_pkg::SKIP_W) ? PW : msbr_pkg::SKIP_W;
    localparam int unsigned MAX_BYTES = (MAX_READ_BITS + 7) / 8;
    localparam int unsigned NBW       = $clog2(MAX_BYTES + 1);
    localparam int unsigned ACC_W     = 7 + 8 * MAX_BYTES;
    localparam int unsigned VW        = msbr_pkg::VALUE_W;

    typedef enum logic [1:0] {S_IDLE, S_FETCH, S_DONE} state_t;

    state_t               state_reg, state_next;
    logic [PW-1:0]        fill_reg, fill_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic [7:0]           hbyte_reg, hbyte_next;
    logic [2:0]           hcnt_reg, hcnt_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [2:0]           nh_reg, nh_next;
    logic [NBW-1:0]       nbytes_reg, nbytes_next;
    logic [NBW-1:0]       issue_reg, issue_next;
    logic [NBW-1:0]       take_reg, take_next;
    logic                 pend_reg, pend_next;
    logic                 err_reg, err_next;

    logic                 mem_en, mem_we;
    logic [AW-1:0]        mem_addr;
    logic [7:0]           mem_rdata;

    logic [PW-1:0]        avail;
    logic [7:0]           held_pick;
    logic [7:0]           held_mask;
    logic [5:0]           need_c;
    logic [NBW-1:0]       nbytes_c;
    logic [2:0]           nh_c;
    logic [ACC_W-1:0]     acc_shift;
    logic [ACC_W+VW-1:0]  acc_wide;

    msbr_store #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (byte_value),
        .rdata (mem_rdata)
    );

    assign avail     = fill_reg - pos_reg;
    assign held_pick = (hbyte_reg >> (hcnt_reg - bit_count[2:0]))
                       & ((8'd1 << bit_count[2:0]) - 8'd1);
    assign held_mask = hbyte_reg & ((8'd1 << hcnt_reg) - 8'd1);
    assign need_c    = bit_count - {3'b000, hcnt_reg};
    assign nbytes_c  = NBW'(((need_c - 6'd1) >> 3) + 6'd1);
    // unused low bits of the last fetched byte become the new held bits
    assign nh_c      = 3'(6'd0 - need_c);

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        hbyte_next  = hbyte_reg;
        hcnt_next   = hcnt_reg;
        acc_next    = acc_reg;
        nh_next     = nh_reg;
        nbytes_next = nbytes_reg;
        issue_next  = issue_reg;
        take_next   = take_reg;
        pend_next   = 1'b0;
        err_next    = err_reg;
        mem_en      = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = AW'(pos_reg + PW'(issue_reg));
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    err_next   = 1'b0;
                    acc_next   = '0;
                    nh_next    = 3'd0;
                    state_next = S_DONE;
                    case (msbr_pkg::msbr_op_t'(opcode))
                        msbr_pkg::OP_APPEND: begin
                            if (fill_reg < PW'(STORE_BYTES)) begin
                                mem_en    = 1'b1;
                                mem_we    = 1'b1;
                                mem_addr  = AW'(fill_reg);
                                fill_next = fill_reg + PW'(1);
                            end else begin
                                err_next = 1'b1;
                            end
                        end
                        msbr_pkg::OP_READ: begin
                            if (bit_count > 6'(MAX_READ_BITS)) begin
                                err_next = 1'b1;
                            end else if (bit_count <= {3'b000, hcnt_reg}) begin
                                acc_next  = ACC_W'(held_pick);
                                hcnt_next = hcnt_reg - bit_count[2:0];
                            end else if (avail < PW'(nbytes_c)) begin
                                err_next = 1'b1;
                            end else begin
                                acc_next    = ACC_W'(held_mask);
                                nh_next     = nh_c;
                                nbytes_next = nbytes_c;
                                issue_next  = '0;
                                take_next   = '0;
                                state_next  = S_FETCH;
                            end
                        end
                        msbr_pkg::OP_SKIP: begin
                            if (CW'(avail) >= CW'(skip_count)) begin
                                pos_next = pos_reg + PW'(skip_count);
                            end else begin
                                err_next = 1'b1;
                            end
                        end
                        msbr_pkg::OP_REWIND: begin
                            pos_next   = '0;
                            hbyte_next = 8'd0;
                            hcnt_next  = 3'd0;
                        end
                        msbr_pkg::OP_CLEAR: begin
                            fill_next  = '0;
                            pos_next   = '0;
                            hbyte_next = 8'd0;
                            hcnt_next  = 3'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                // issue one address a cycle, capture each byte in the cycle after its address
                if (issue_reg != nbytes_reg) begin
                    mem_en     = 1'b1;
                    pend_next  = 1'b1;
                    issue_next = issue_reg + NBW'(1);
                end
                if (pend_reg) begin
                    acc_next  = {acc_reg[ACC_W-9:0], mem_rdata};
                    take_next = take_reg + NBW'(1);
                    if (take_reg == nbytes_reg - NBW'(1)) begin
                        pos_next   = pos_reg + PW'(nbytes_reg);
                        hcnt_next  = nh_reg;
                        hbyte_next = mem_rdata;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            pos_reg   <= '0;
            hbyte_reg <= 8'd0;
            hcnt_reg  <= 3'd0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
            hbyte_reg <= hbyte_next;
            hcnt_reg  <= hcnt_next;
            pend_reg  <= pend_next;
        end
        acc_reg    <= acc_next;
        nh_reg     <= nh_next;
        nbytes_reg <= nbytes_next;
        issue_reg  <= issue_next;
        take_reg   <= take_next;
        err_reg    <= err_next;
    end

    assign acc_shift = acc_reg >> nh_reg;
    assign acc_wide  = {{VW{1'b0}}, acc_shift};

    assign ready                    = (state_reg == S_IDLE);
    assign res_valid                = (state_reg == S_DONE);
    assign result.bits_value        = acc_wide[VW-1:0];
    assign result.out_of_bounds     = err_reg;
    assign result.bits_to_alignment = hcnt_reg;

endmodule

@@ rtl/msb_first_bit_reader.sv @@
// MSB-first bit reader top level: stream ports, command sequencer and result register.
// Result path: every command moves the sequencer to its done state, then the result word
//   passes through the output register; a read that fetches N bytes (1..4) first visits the fetch state.
// Throughput: one command at a time; the single-port byte store delivers one byte a cycle.
// The next command is taken once the previous result has moved into the output register.
// Reset (aresetn low, synchronous): fill length, read position and held bits go to zero;
//   the byte store is not cleared and holds garbage until written.
module msb_first_bit_reader #(
    parameter int unsigned STORE_BYTES   = msbr_pkg::STORE_BYTES_DEF,
    parameter int unsigned MAX_READ_BITS = msbr_pkg::MAX_READ_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // command stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] byte_value, [13:8] bit_count, [26:14] skip_count, [31:27] zero
    input  logic [msbr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [2:0] opcode
    input  logic [msbr_pkg::OPCODE_W-1:0]    s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] bits_value, [32] out_of_bounds, [35:33] bits_to_alignment, [39:36] zero
    output logic [msbr_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int unsigned PAD_W = msbr_pkg::M_TDATA_W - msbr_pkg::VALUE_W
                                    - 1 - msbr_pkg::ALIGN_W;

    logic                   core_start;
    logic                   core_ready;
    logic                   core_res_valid;
    msbr_pkg::msbr_result_t core_result;

    // output register: a finished result waits here while the core moves on
    logic                   out_free;
    logic                   push;
    logic                   m_valid_reg, m_valid_next;
    msbr_pkg::msbr_result_t m_data_reg, m_data_next;

    assign core_start    = s_axis_tvalid && core_ready;
    assign s_axis_tready = core_ready;

    msbr_core #(
        .STORE_BYTES   (STORE_BYTES),
        .MAX_READ_BITS (MAX_READ_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (core_start),
        .opcode     (s_axis_tuser),
        .byte_value (s_axis_tdata[7:0]),
        .bit_count  (s_axis_tdata[13:8]),
        .skip_count (s_axis_tdata[26:14]),
        .ready      (core_ready),
        .res_valid  (core_res_valid),
        .res_take   (out_free),
        .result     (core_result)
    );

    assign out_free = !m_valid_reg || m_axis_tready;
    assign push     = core_res_valid && out_free;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (push) begin
            m_valid_next = 1'b1;
            m_data_next  = core_result;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, m_data_reg};

`ifndef NO_ASSERTIONS
    // an accepted command leaves the sequencer busy, so no second word is taken straight after it
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("reader took a second word right after a command");

    // failed reads, skips and appends never return data bits
    a_error_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[32]) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("out-of-bounds result carries nonzero bits");

    // a new result only follows a cycle in which the sequencer was busy
    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a command in flight");
`endif

endmodule
